/* hw/rtl/float_to_int_quantizer_assert.svh */
// assertion macros used by the quantizer top level
// expects clk and rst_n in the scope of each use
`ifndef FLOAT_TO_INT_QUANTIZER_ASSERT_SVH
`define FLOAT_TO_INT_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FIQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quantizer check failed");
// next-cycle implication
`define FIQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quantizer check failed");
`else
`define FIQ_ASSERT_IMPLY(lbl, ante, cons)
`define FIQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/fiq_pkg.sv */
// types, constants and range functions for the float to int quantizer
// no dependencies
`default_nettype none

package fiq_pkg;

  localparam int unsigned MantW  = 24;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned ScaleW = 48;
  localparam int unsigned PartW  = 48;
  localparam int unsigned ProdW  = 72;
  localparam int unsigned MagW   = 41;
  localparam int unsigned ExpW   = 10;
  localparam int unsigned OffW   = 33;
  localparam int unsigned QW     = 33;
  localparam int unsigned AccW   = 44;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned IdxW   = 2;

  // rounded magnitude saturates here
  localparam logic [MagW-1:0] MagCap = 41'h100_0000_0000;

  // output type codes
  localparam logic [TypeW-1:0] OT_INT8   = 3'd0;
  localparam logic [TypeW-1:0] OT_UINT8  = 3'd1;
  localparam logic [TypeW-1:0] OT_INT16  = 3'd2;
  localparam logic [TypeW-1:0] OT_UINT16 = 3'd3;
  localparam logic [TypeW-1:0] OT_INT32  = 3'd4;
  localparam logic [TypeW-1:0] OT_UINT32 = 3'd5;

  // config register indexes
  localparam logic [IdxW-1:0] REG_OUT_TYPE = 2'd0;
  localparam logic [IdxW-1:0] REG_SCALE    = 2'd1;
  localparam logic [IdxW-1:0] REG_OFFSET   = 2'd2;

  localparam logic [ScaleW-1:0] ScaleReset = 48'd16777216;

  localparam logic signed [QW-1:0] Int8Min   = -33'sd128;
  localparam logic signed [QW-1:0] Int8Max   = 33'sd127;
  localparam logic signed [QW-1:0] Uint8Max  = 33'sd255;
  localparam logic signed [QW-1:0] Int16Min  = -33'sd32768;
  localparam logic signed [QW-1:0] Int16Max  = 33'sd32767;
  localparam logic signed [QW-1:0] Uint16Max = 33'sd65535;
  localparam logic signed [QW-1:0] Int32Min  = -33'sd2147483648;
  localparam logic signed [QW-1:0] Int32Max  = 33'sd2147483647;
  localparam logic signed [QW-1:0] Uint32Max = 33'sd4294967295;
  localparam logic signed [QW-1:0] UintMin   = 33'sd0;

  // after decode and the two partial products
  typedef struct packed {
    logic                   sign;
    logic                   special;
    logic                   spec_max;
    logic [ExpW-1:0]        exp2;
    logic [PartW-1:0]       part_hi;
    logic [PartW-1:0]       part_lo;
    logic                   last;
  } mul_stage_t;

  // after the full product is summed
  typedef struct packed {
    logic                   sign;
    logic                   special;
    logic                   spec_max;
    logic [ExpW-1:0]        exp2;
    logic [ProdW-1:0]       prod;
    logic                   last;
  } sum_stage_t;

  // after alignment and rounding
  typedef struct packed {
    logic                   sign;
    logic                   special;
    logic                   spec_max;
    logic [MagW-1:0]        mag;
    logic                   last;
  } rnd_stage_t;

  // lower bound of the selected type, undefined codes act as int8
  function automatic logic signed [QW-1:0] type_min(input logic [TypeW-1:0] t);
    logic signed [QW-1:0] v;
    case (t) inside
      OT_UINT8, OT_UINT16, OT_UINT32: v = UintMin;
      OT_INT16:                       v = Int16Min;
      OT_INT32:                       v = Int32Min;
      default:                        v = Int8Min;
    endcase
    return v;
  endfunction

  // upper bound of the selected type, undefined codes act as int8
  function automatic logic signed [QW-1:0] type_max(input logic [TypeW-1:0] t);
    logic signed [QW-1:0] v;
    case (t)
      OT_UINT8:  v = Uint8Max;
      OT_INT16:  v = Int16Max;
      OT_UINT16: v = Uint16Max;
      OT_INT32:  v = Int32Max;
      OT_UINT32: v = Uint32Max;
      default:   v = Int8Max;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fiq_mult.sv */
// stage 1: float decode and two 24x24 partial products of mantissa and scale
// depends on fiq_pkg
`default_nettype none

module fiq_mult import fiq_pkg::*; #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              valid_in,
  input  wire logic [31:0]       sample_bits,
  input  wire logic              last_in,
  input  wire logic [ScaleW-1:0] scale_fixed,
  output logic                   valid_r,
  output mul_stage_t             stage_r
);

  localparam int unsigned ExpBias = 150 + SCALE_FRAC_BITS;

  logic [7:0]       bexp;
  logic [22:0]      frac;
  logic [MantW-1:0] mant;
  logic [7:0]       eff_exp;
  mul_stage_t       stage_nxt;

  // field decode, subnormals use exponent one and no hidden bit
  always_comb begin
    bexp    = sample_bits[30:23];
    frac    = sample_bits[22:0];
    mant    = (bexp == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    eff_exp = (bexp == 8'd0) ? 8'd1 : bexp;

    stage_nxt.sign     = sample_bits[31];
    stage_nxt.special  = (bexp == 8'hFF);
    stage_nxt.spec_max = !sample_bits[31] && (frac == 23'd0);
    stage_nxt.exp2     = {2'b00, eff_exp} - ExpW'(ExpBias);
    stage_nxt.part_hi  = mant * scale_fixed[ScaleW-1:HalfW];
    stage_nxt.part_lo  = mant * scale_fixed[HalfW-1:0];
    stage_nxt.last     = last_in;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fiq_sum.sv */
// stage 2: sums the partial products into the exact 72-bit product
// depends on fiq_pkg
`default_nettype none

module fiq_sum import fiq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic       valid_in,
  input  mul_stage_t      stage_in,
  output logic            valid_r,
  output sum_stage_t      stage_r
);

  sum_stage_t stage_nxt;

  // product = hi * 2^24 + lo
  always_comb begin
    stage_nxt.sign     = stage_in.sign;
    stage_nxt.special  = stage_in.special;
    stage_nxt.spec_max = stage_in.spec_max;
    stage_nxt.exp2     = stage_in.exp2;
    stage_nxt.prod     = {stage_in.part_hi, {HalfW{1'b0}}}
                       + {{(ProdW-PartW){1'b0}}, stage_in.part_lo};
    stage_nxt.last     = stage_in.last;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fiq_round.sv */
// stage 3: aligns the product by the exponent, rounds half to even, saturates
// depends on fiq_pkg
`default_nettype none

module fiq_round import fiq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       adv,
  input  wire logic       valid_in,
  input  sum_stage_t      stage_in,
  output logic            valid_r,
  output rnd_stage_t      stage_r
);

  localparam int unsigned LeftW = 2 * MagW;

  logic                 go_left;
  logic                 big_left;
  logic [LeftW-1:0]     left_shifted;
  logic                 left_cap;
  logic [MagW-1:0]      left_mag;
  logic [ExpW-1:0]      sh_full;
  logic                 right_zero;
  logic [6:0]           sh;
  logic [6:0]           sh_m1;
  logic [ProdW-1:0]     quot;
  logic [ProdW-1:0]     rb_vec;
  logic [ProdW-1:0]     sticky_mask;
  logic                 round_bit;
  logic                 sticky;
  logic                 round_up;
  logic [ProdW:0]       quot_rnd;
  logic [MagW-1:0]      right_mag;
  rnd_stage_t           stage_nxt;

  always_comb begin
    go_left = !stage_in.exp2[ExpW-1];

    // left shift: a zero product stays zero, else saturate once past the cap
    big_left     = (stage_in.exp2[ExpW-2:0] >= (ExpW-1)'(MagW));
    left_shifted = {{(LeftW-MagW){1'b0}}, stage_in.prod[MagW-1:0]}
                   << stage_in.exp2[5:0];
    left_cap     = (|stage_in.prod)
                   && ((|stage_in.prod[ProdW-1:MagW]) || big_left
                   || (left_shifted > {{(LeftW-MagW){1'b0}}, MagCap}));
    left_mag     = left_cap ? MagCap : left_shifted[MagW-1:0];

    // right shift: a shift beyond the 72-bit product rounds to zero
    sh_full    = {ExpW{1'b0}} - stage_in.exp2;
    right_zero = (sh_full >= ExpW'(ProdW + 1));
    sh         = sh_full[6:0];
    sh_m1      = sh - 7'd1;

    quot        = stage_in.prod >> sh;
    rb_vec      = stage_in.prod >> sh_m1;
    round_bit   = rb_vec[0];
    sticky_mask = ({{(ProdW-1){1'b0}}, 1'b1} << sh_m1) - {{(ProdW-1){1'b0}}, 1'b1};
    sticky      = |(stage_in.prod & sticky_mask);
    round_up    = round_bit && (sticky || quot[0]);
    quot_rnd    = {1'b0, quot} + {{ProdW{1'b0}}, round_up};

    if (right_zero) begin
      right_mag = {MagW{1'b0}};
    end else if (quot_rnd > {{(ProdW+1-MagW){1'b0}}, MagCap}) begin
      right_mag = MagCap;
    end else begin
      right_mag = quot_rnd[MagW-1:0];
    end

    stage_nxt.sign     = stage_in.sign;
    stage_nxt.special  = stage_in.special;
    stage_nxt.spec_max = stage_in.spec_max;
    stage_nxt.mag      = go_left ? left_mag : right_mag;
    stage_nxt.last     = stage_in.last;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fiq_clamp.sv */
// stage 4: applies sign, offset and type minimum, clamps, holds the result
// depends on fiq_pkg
`default_nettype none

module fiq_clamp import fiq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              valid_in,
  input  rnd_stage_t             stage_in,
  input  wire logic [TypeW-1:0]  out_type,
  input  wire logic [OffW-1:0]   zero_offset,
  output logic                   valid_r,
  output logic signed [QW-1:0]   quantized_r,
  output logic                   last_r
);

  logic signed [QW-1:0]   tmin;
  logic signed [QW-1:0]   tmax;
  logic signed [AccW-1:0] mag_ext;
  logic signed [AccW-1:0] rnd_val;
  logic signed [AccW-1:0] off_ext;
  logic signed [AccW-1:0] tmin_ext;
  logic signed [AccW-1:0] tmax_ext;
  logic signed [AccW-1:0] acc;
  logic signed [QW-1:0]   quantized_nxt;

  always_comb begin
    tmin     = type_min(out_type);
    tmax     = type_max(out_type);
    mag_ext  = {{(AccW-MagW){1'b0}}, stage_in.mag};
    rnd_val  = stage_in.sign ? ({AccW{1'b0}} - mag_ext) : mag_ext;
    off_ext  = {{(AccW-OffW){zero_offset[OffW-1]}}, zero_offset};
    tmin_ext = {{(AccW-QW){tmin[QW-1]}}, tmin};
    tmax_ext = {{(AccW-QW){tmax[QW-1]}}, tmax};
    acc      = rnd_val - off_ext + tmin_ext;

    // infinities saturate by sign, nan goes low
    if (stage_in.special) begin
      quantized_nxt = stage_in.spec_max ? tmax : tmin;
    end else if (acc < tmin_ext) begin
      quantized_nxt = tmin;
    end else if (acc > tmax_ext) begin
      quantized_nxt = tmax;
    end else begin
      quantized_nxt = acc[QW-1:0];
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      quantized_r <= quantized_nxt;
      last_r      <= stage_in.last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/float_to_int_quantizer.sv */
// Float32 to integer affine quantizer. One request per clock is accepted
// while in_stall is low, and one result is returned per request, in order.
// The four stages are: decode and two 24x24 partial products, the 72-bit
// product sum, exponent alignment with round-half-to-even, and offset/clamp
// into the output register. All stages advance independently, so a stalled
// result does not block accepting new requests until the pipeline is full.
// Config writes are always ready and take effect immediately; write them
// only while no request is in flight.
// depends on fiq_pkg, fiq_mult, fiq_sum, fiq_round, fiq_clamp and float_to_int_quantizer_assert.svh
`default_nettype none
`include "float_to_int_quantizer_assert.svh"

module float_to_int_quantizer import fiq_pkg::*; #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       in_sample_bits,
  input  wire logic              in_last_in,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [QW-1:0]   out_quantized,
  output logic                   out_last_out,
  // config write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IdxW-1:0]   cfg_index,
  input  wire logic [ScaleW-1:0] cfg_data
);

  logic [TypeW-1:0]  out_type_r;
  logic [ScaleW-1:0] scale_fixed_r;
  logic [OffW-1:0]   zero_offset_r;

  logic       adv1;
  logic       adv2;
  logic       adv3;
  logic       adv4;
  logic       s1_valid;
  logic       s2_valid;
  logic       s3_valid;
  mul_stage_t s1;
  sum_stage_t s2;
  rnd_stage_t s3;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_type_r    <= OT_INT8;
      scale_fixed_r <= ScaleReset;
      zero_offset_r <= {OffW{1'b0}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUT_TYPE: out_type_r    <= cfg_data[TypeW-1:0];
        REG_SCALE:    scale_fixed_r <= cfg_data;
        REG_OFFSET:   zero_offset_r <= cfg_data[OffW-1:0];
        default:      ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  fiq_mult #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_mult (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv1),
    .valid_in    (in_valid),
    .sample_bits (in_sample_bits),
    .last_in     (in_last_in),
    .scale_fixed (scale_fixed_r),
    .valid_r     (s1_valid),
    .stage_r     (s1)
  );

  fiq_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv2),
    .valid_in (s1_valid),
    .stage_in (s1),
    .valid_r  (s2_valid),
    .stage_r  (s2)
  );

  fiq_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv3),
    .valid_in (s2_valid),
    .stage_in (s2),
    .valid_r  (s3_valid),
    .stage_r  (s3)
  );

  fiq_clamp u_clamp (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv4),
    .valid_in    (s3_valid),
    .stage_in    (s3),
    .out_type    (out_type_r),
    .zero_offset (zero_offset_r),
    .valid_r     (out_valid),
    .quantized_r (out_quantized),
    .last_r      (out_last_out)
  );

  // request side only stalls when the first stage is occupied
  `FIQ_ASSERT_IMPLY(a_stall_needs_full, in_stall, s1_valid)
  // rounded magnitude never passes the saturation cap
  `FIQ_ASSERT_IMPLY(a_mag_capped, s3_valid, s3.mag <= MagCap)
  // a stalled result holds the stage behind it in place
  `FIQ_ASSERT_NEXT(a_rnd_held, s3_valid && out_valid && out_stall, s3_valid && $stable(s3))

endmodule

`default_nettype wire
